// ===== design/bsc_pkg.sv =====
// Shared types and constants for the barometric sensor compensation pipeline.
package bsc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TEMP    = 2'd0;
  localparam logic [1:0] CFG_PRESS_A = 2'd1;
  localparam logic [1:0] CFG_PRESS_B = 2'd2;
  localparam logic [1:0] CFG_PRESS_C = 2'd3;

  // Formula constants.
  localparam int TEMP_OFFSET = 128000;
  localparam int PRESS_BASE  = 1048576;
  localparam int PRESS_SCALE = 3125;
  localparam int TEMP_ROUND  = 128;

  // One quotient bit per divider stage.
  localparam int DIV_STEPS = 64;

  // Data that rides alongside the divider.
  typedef struct packed {
    logic [23:0] temp_centi;
    logic        div_zero;
  } side_t;

endpackage

// ===== design/bsc_div.sv =====
// Pipelined restoring divider for 64-bit magnitudes, one quotient bit per stage.
module bsc_div
  import bsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [63:0]        num_i,
  input  logic [63:0]        den_i,
  input  logic               neg_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic signed [63:0] quot_o,
  output side_t              side_o
);

  logic [63:0] rem_q  [DIV_STEPS];
  logic [63:0] nq_q   [DIV_STEPS];
  logic [63:0] den_q  [DIV_STEPS];
  logic        neg_q  [DIV_STEPS];
  side_t       side_q [DIV_STEPS];
  logic        vld_q  [DIV_STEPS];

  logic               out_vld_q;
  logic signed [63:0] out_quot_q;
  side_t              out_side_q;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [63:0] rem_in;
    logic [63:0] nq_in;
    logic [63:0] den_in;
    logic        neg_in;
    side_t       side_in;
    logic        vld_in;
    logic [65:0] trial;
    logic [63:0] rem_d;
    logic [63:0] nq_d;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign neg_in  = neg_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign nq_in   = nq_q[i-1];
      assign den_in  = den_q[i-1];
      assign neg_in  = neg_q[i-1];
      assign side_in = side_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    // The partial remainder stays below the divisor, so it fits in 64 bits.
    always_comb begin
      trial = {1'b0, rem_in, nq_in[63]} - {2'b00, den_in};
      if (!trial[65]) begin
        rem_d = trial[63:0];
        nq_d  = {nq_in[62:0], 1'b1};
      end else begin
        rem_d = {rem_in[62:0], nq_in[63]};
        nq_d  = {nq_in[62:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        nq_q[i]   <= nq_d;
        den_q[i]  <= den_in;
        neg_q[i]  <= neg_in;
        side_q[i] <= side_in;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[DIV_STEPS-1];
    end
  end

  // Apply the quotient sign; the most negative result wraps onto itself.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_quot_q <= neg_q[DIV_STEPS-1] ? $signed(-nq_q[DIV_STEPS-1])
                                       : $signed(nq_q[DIV_STEPS-1]);
      out_side_q <= side_q[DIV_STEPS-1];
    end
  end

  assign valid_o = out_vld_q;
  assign quot_o  = out_quot_q;
  assign side_o  = out_side_q;

endmodule

// ===== design/barometric_sensor_compensation.sv =====
// Top level of the barometric temperature and pressure compensation pipeline.
//
// Usage: each input beat on the s_axis channel carries one pair of raw 20-bit
// readings, temperature and pressure. Each beat yields exactly one output beat
// on the m_axis channel with the temperature in hundredths of a degree, the
// pressure in unsigned Q24.8 pascal and in whole pascal. tuser flags a zero
// pressure divisor, in which case both pressure fields are zero.
// The user must write calibration words through the cfg port only while no beat is
// in flight; the block does not enforce this. Register index and data are sampled
// on any rising edge with cfg_we_i high. From input beat to output beat there are
// nine stages for the temperature and pressure polynomials, one for operand signs,
// 64 divider stages that each resolve one quotient bit, one for the quotient sign,
// and four for the pressure correction terms including the output register.
// One beat per cycle unless the receiver stalls; the pipeline is fully populated.
// Reset clears all valid bits and the calibration registers.
// When the receiver deasserts m_axis_tready while a result is held, the whole
// pipeline freezes and s_axis_tready drops; nothing is lost or repeated.
module barometric_sensor_compensation
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // raw_temperature[19:0], raw_pressure[39:20]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // temperature_centi[23:0], pressure_fixed[55:24],
                                     // pressure_pascal[79:56]
  output logic        m_axis_tuser,  // divisor_zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  // Calibration registers.
  logic [47:0] cfg_temp_q;
  logic [63:0] cfg_pa_q;
  logic [63:0] cfg_pb_q;
  logic [15:0] cfg_pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_temp_q <= '0;
      cfg_pa_q   <= '0;
      cfg_pb_q   <= '0;
      cfg_pc_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEMP:    cfg_temp_q <= cfg_data_i[47:0];
        CFG_PRESS_A: cfg_pa_q   <= cfg_data_i;
        CFG_PRESS_B: cfg_pb_q   <= cfg_data_i;
        CFG_PRESS_C: cfg_pc_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Coefficient slices.
  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = cfg_temp_q[15:0];
  assign t2 = $signed(cfg_temp_q[31:16]);
  assign t3 = $signed(cfg_temp_q[47:32]);
  assign p1 = cfg_pa_q[15:0];
  assign p2 = $signed(cfg_pa_q[31:16]);
  assign p3 = $signed(cfg_pa_q[47:32]);
  assign p4 = $signed(cfg_pa_q[63:48]);
  assign p5 = $signed(cfg_pb_q[15:0]);
  assign p6 = $signed(cfg_pb_q[31:16]);
  assign p7 = $signed(cfg_pb_q[47:32]);
  assign p8 = $signed(cfg_pb_q[63:48]);
  assign p9 = $signed(cfg_pc_q);

  // The whole pipeline advances together whenever the output slot is free.
  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: temperature differences and their first products.
  logic        [31:0] s1_a, s1_d;
  logic signed [31:0] s1_ma_d, s1_dd_d, s1_ma_q, s1_dd_q;
  logic        [19:0] s1_ap_q;
  logic               s1_vld_q;

  always_comb begin
    s1_a    = 32'(s_axis_tdata[19:3]) - 32'({t1, 1'b0});
    s1_d    = 32'(s_axis_tdata[19:4]) - 32'(t1);
    s1_ma_d = $signed(s1_a) * 32'(t2);
    s1_dd_d = $signed(s1_d) * $signed(s1_d);
  end

  // Stage 2: scale and multiply the squared term by T3.
  logic signed [31:0] s2_a_d, s2_b, s2_mb_d, s2_a_q, s2_mb_q;
  logic        [19:0] s2_ap_q;
  logic               s2_vld_q;

  always_comb begin
    s2_a_d  = s1_ma_q >>> 11;
    s2_b    = s1_dd_q >>> 12;
    s2_mb_d = s2_b * 32'(t3);
  end

  // Stage 3: fine temperature.
  logic signed [31:0] s3_tf_d, s3_tf_q;
  logic        [19:0] s3_ap_q;
  logic               s3_vld_q;

  assign s3_tf_d = s2_a_q + (s2_mb_q >>> 14);

  // Stage 4: centi-degree output and the pressure offset term.
  logic signed [31:0] s4_t5;
  logic signed [23:0] s4_tc_d, s4_tc_q;
  logic signed [32:0] s4_v1_d, s4_v1_q;
  logic        [19:0] s4_ap_q;
  logic               s4_vld_q;

  always_comb begin
    s4_t5   = s3_tf_q * 32'sd5 + 32'(TEMP_ROUND);
    s4_tc_d = 24'(s4_t5 >>> 8);
    s4_v1_d = 33'(s3_tf_q) - 33'(TEMP_OFFSET);
  end

  // Stage 5: square of the offset and the linear products.
  logic signed [63:0] s5_v1x, s5_sq_d, s5_m5_d, s5_m2_d, s5_sq_q, s5_m5_q, s5_m2_q;
  logic signed [23:0] s5_tc_q;
  logic        [19:0] s5_ap_q;
  logic               s5_vld_q;

  always_comb begin
    s5_v1x  = 64'(s4_v1_q);
    s5_sq_d = s5_v1x * s5_v1x;
    s5_m5_d = s5_v1x * 64'(p5);
    s5_m2_d = s5_v1x * 64'(p2);
  end

  // Stage 6: quadratic terms.
  logic signed [63:0] s6_v2a_d, s6_v1a_d, s6_v2a_q, s6_v1a_q, s6_m5_q, s6_m2_q;
  logic signed [23:0] s6_tc_q;
  logic        [19:0] s6_ap_q;
  logic               s6_vld_q;

  always_comb begin
    s6_v2a_d = s5_sq_q * 64'(p6);
    s6_v1a_d = s5_sq_q * 64'(p3);
  end

  // Stage 7: sum the offset and sensitivity polynomials.
  logic signed [63:0] s7_v2_d, s7_v1_d, s7_v2_q, s7_v1_q;
  logic signed [23:0] s7_tc_q;
  logic        [19:0] s7_ap_q;
  logic               s7_vld_q;

  always_comb begin
    s7_v2_d = s6_v2a_q + (s6_m5_q <<< 17) + (64'(p4) <<< 35);
    s7_v1_d = (s6_v1a_q >>> 8) + (s6_m2_q <<< 12);
  end

  // Stage 8: sensitivity times P1, numerator base.
  logic        [20:0] s8_pn;
  logic signed [63:0] s8_v1_d, s8_num_d, s8_v1_q, s8_num_q;
  logic signed [23:0] s8_tc_q;
  logic               s8_vld_q;

  always_comb begin
    s8_v1_d  = (s7_v1_q + (64'sd1 <<< 47)) * $signed({48'b0, p1});
    s8_pn    = 21'(PRESS_BASE) - {1'b0, s7_ap_q};
    s8_num_d = ($signed({43'b0, s8_pn}) <<< 31) - s7_v2_q;
  end

  // Stage 9: divisor and scaled numerator.
  logic signed [63:0] s9_den_d, s9_num_d, s9_den_q, s9_num_q;
  logic signed [23:0] s9_tc_q;
  logic               s9_vld_q;

  always_comb begin
    s9_den_d = s8_v1_q >>> 33;
    s9_num_d = s8_num_q * 64'(PRESS_SCALE);
  end

  // Stage 10: operand magnitudes and quotient sign for the divider.
  logic [63:0] s10_mn_d, s10_md_d, s10_mn_q, s10_md_q;
  logic        s10_neg_q;
  side_t       s10_side_d, s10_side_q;
  logic        s10_vld_q;

  always_comb begin
    s10_mn_d = s9_num_q[63] ? 64'(-s9_num_q) : 64'(s9_num_q);
    s10_md_d = s9_den_q[63] ? 64'(-s9_den_q) : 64'(s9_den_q);
    s10_side_d.temp_centi = s9_tc_q;
    s10_side_d.div_zero   = (s9_den_q == 64'sd0);
  end

  logic               dv_vld;
  logic signed [63:0] dv_quot;
  side_t              dv_side;

  bsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s10_vld_q),
    .num_i   (s10_mn_q),
    .den_i   (s10_md_q),
    .neg_i   (s10_neg_q),
    .side_i  (s10_side_q),
    .valid_o (dv_vld),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // Post stage A: split square of the scaled quotient, P8 product.
  logic signed [63:0] qa_x;
  logic        [31:0] qa_lh;
  logic        [63:0] qa_ll_d, qa_ll_q;
  logic        [30:0] qa_lh_q;
  logic signed [63:0] qa_m8_d, qa_m8_q, qa_p_q;
  side_t              qa_side_q;
  logic               qa_vld_q;

  always_comb begin
    qa_x    = dv_quot >>> 13;
    qa_ll_d = 64'(qa_x[31:0]) * 64'(qa_x[31:0]);
    qa_lh   = qa_x[31:0] * qa_x[63:32];
    qa_m8_d = dv_quot * 64'(p8);
  end

  // Post stage B: assemble the square, scale the P8 term.
  logic        [63:0] qb_xx_d, qb_xx_q;
  logic signed [63:0] qb_v2_d, qb_v2_q, qb_p_q;
  side_t              qb_side_q;
  logic               qb_vld_q;

  always_comb begin
    qb_xx_d = qa_ll_q + {qa_lh_q, 33'b0};
    qb_v2_d = qa_m8_q >>> 19;
  end

  // Post stage C: P9 times the square.
  logic signed [63:0] qc_m9_d, qc_m9_q, qc_v2_q, qc_p_q;
  side_t              qc_side_q;
  logic               qc_vld_q;

  assign qc_m9_d = $signed(qb_xx_q) * 64'(p9);

  // Output stage: final pressure sum.
  logic signed [63:0] qd_pf;
  logic        [79:0] out_data_d, out_data_q;
  logic               out_user_q;

  always_comb begin
    qd_pf = ((qc_p_q + (qc_m9_q >>> 25) + qc_v2_q) >>> 8) + (64'(p7) <<< 4);
    if (qc_side_q.div_zero) begin
      out_data_d = {24'b0, 32'b0, qc_side_q.temp_centi};
    end else begin
      out_data_d = {qd_pf[31:8], qd_pf[31:0], qc_side_q.temp_centi};
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      qa_vld_q  <= 1'b0;
      qb_vld_q  <= 1'b0;
      qc_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= s_axis_tvalid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
      qa_vld_q  <= dv_vld;
      qb_vld_q  <= qa_vld_q;
      qc_vld_q  <= qb_vld_q;
      out_vld_q <= qc_vld_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ma_q    <= s1_ma_d;
      s1_dd_q    <= s1_dd_d;
      s1_ap_q    <= s_axis_tdata[39:20];
      s2_a_q     <= s2_a_d;
      s2_mb_q    <= s2_mb_d;
      s2_ap_q    <= s1_ap_q;
      s3_tf_q    <= s3_tf_d;
      s3_ap_q    <= s2_ap_q;
      s4_tc_q    <= s4_tc_d;
      s4_v1_q    <= s4_v1_d;
      s4_ap_q    <= s3_ap_q;
      s5_sq_q    <= s5_sq_d;
      s5_m5_q    <= s5_m5_d;
      s5_m2_q    <= s5_m2_d;
      s5_tc_q    <= s4_tc_q;
      s5_ap_q    <= s4_ap_q;
      s6_v2a_q   <= s6_v2a_d;
      s6_v1a_q   <= s6_v1a_d;
      s6_m5_q    <= s5_m5_q;
      s6_m2_q    <= s5_m2_q;
      s6_tc_q    <= s5_tc_q;
      s6_ap_q    <= s5_ap_q;
      s7_v2_q    <= s7_v2_d;
      s7_v1_q    <= s7_v1_d;
      s7_tc_q    <= s6_tc_q;
      s7_ap_q    <= s6_ap_q;
      s8_v1_q    <= s8_v1_d;
      s8_num_q   <= s8_num_d;
      s8_tc_q    <= s7_tc_q;
      s9_den_q   <= s9_den_d;
      s9_num_q   <= s9_num_d;
      s9_tc_q    <= s8_tc_q;
      s10_mn_q   <= s10_mn_d;
      s10_md_q   <= s10_md_d;
      s10_neg_q  <= s9_num_q[63] ^ s9_den_q[63];
      s10_side_q <= s10_side_d;
      qa_ll_q    <= qa_ll_d;
      qa_lh_q    <= qa_lh[30:0];
      qa_m8_q    <= qa_m8_d;
      qa_p_q     <= dv_quot;
      qa_side_q  <= dv_side;
      qb_xx_q    <= qb_xx_d;
      qb_v2_q    <= qb_v2_d;
      qb_p_q     <= qa_p_q;
      qb_side_q  <= qa_side_q;
      qc_m9_q    <= qc_m9_d;
      qc_v2_q    <= qb_v2_q;
      qc_p_q     <= qb_p_q;
      qc_side_q  <= qb_side_q;
      out_data_q <= out_data_d;
      out_user_q <= qc_side_q.div_zero;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== verif/tb_barometric_sensor_compensation.sv =====
// Self-checking testbench for the barometric sensor compensation pipeline.
module tb_barometric_sensor_compensation;
  import bsc_pkg::*;

  // Result fields that one output beat carries.
  typedef struct packed {
    logic [23:0] temp_centi;
    logic [31:0] press_fixed;
    logic [23:0] press_pa;
    logic        div_zero;
  } comp_result_t;

  localparam int PIPE_LATENCY = 79;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // raw_temperature[19:0], raw_pressure[39:20]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;       // temperature_centi, pressure_fixed, pressure_pascal
  logic        m_axis_tuser;       // divisor_zero
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  barometric_sensor_compensation DUT (.*);

  always #10 clk_i = ~clk_i;

  // Local copy of the calibration registers.
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a, cal_press_b;
  logic [15:0] cal_press_c;

  comp_result_t pending_results[$];
  int  mismatch_count = 0;
  int  unexpected_count = 0;
  longint cycle_count = 0;
  bit  hold_off = 1'b0;   // forces the receiver to stall for a long stretch
  int  stall_bias = 0;    // 0: no receiver stalls, otherwise random stalls
  int  rx_stall = 0;      // cycles left in the current receiver stall

  function automatic logic signed [63:0] slice16(logic [63:0] v, int pos);
    logic signed [15:0] s;
    s = v[pos +: 16];
    return 64'(s);
  endfunction

  function automatic logic [63:0] asr(logic [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  // Computes the compensated readings for one raw pair with the current calibration.
  function automatic comp_result_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
    comp_result_t r;
    logic [31:0] t1, t2, t3, a, b, d, tf, tc;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, num, mn, md, q;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = 32'(slice16(64'(cal_temp), 16));
    t3 = 32'(slice16(64'(cal_temp), 32));
    p1 = {48'd0, cal_press_a[15:0]};
    p2 = slice16(cal_press_a, 16);
    p3 = slice16(cal_press_a, 32);
    p4 = slice16(cal_press_a, 48);
    p5 = slice16(cal_press_b, 0);
    p6 = slice16(cal_press_b, 16);
    p7 = slice16(cal_press_b, 32);
    p8 = slice16(cal_press_b, 48);
    p9 = slice16(64'(cal_press_c), 0);
    // Temperature path wraps at 32 bits.
    a = 32'(raw_t >> 3) - (t1 << 1);
    a = asr32(a * t2, 11);
    d = 32'(raw_t >> 4) - t1;
    b = asr32(d * d, 12);
    b = asr32(b * t3, 14);
    tf = a + b;
    tc = asr32(tf * 32'd5 + 32'd128, 8);
    r.temp_centi = tc[23:0];
    // Pressure path wraps at 64 bits.
    v1 = 64'($signed(tf)) - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 0) begin
      r.press_fixed = '0;
      r.press_pa = '0;
      r.div_zero = 1'b1;
      return r;
    end
    p = 64'd1048576 - 64'(raw_p);
    num = ((p << 31) - v2) * 64'd3125;
    // Truncating signed division done on magnitudes, so the most negative
    // quotient over minus one simply wraps.
    mn = num[63] ? -num : num;
    md = v1[63] ? -v1 : v1;
    q = mn / md;
    p = (num[63] != v1[63]) ? -q : q;
    v1 = asr(p9 * asr(p, 13) * asr(p, 13), 25);
    v2 = asr(p8 * p, 19);
    p = asr(p + v1 + v2, 8) + (p7 << 4);
    r.press_fixed = p[31:0];
    r.press_pa = p[31:8];
    r.div_zero = 1'b0;
    return r;
  endfunction

  // Gap length: mostly zero or short, now and then long.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic write_cal(logic [1:0] idx, logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_TEMP:    cal_temp = value[47:0];
      CFG_PRESS_A: cal_press_a = value;
      CFG_PRESS_B: cal_press_b = value;
      CFG_PRESS_C: cal_press_c = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_cal(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                          logic [15:0] pc);
    write_cal(CFG_TEMP, {$urandom, $urandom} & 64'h0000_FFFF_FFFF_FFFF | 64'(tc));
    write_cal(CFG_TEMP, 64'(tc));
    write_cal(CFG_PRESS_A, pa);
    write_cal(CFG_PRESS_B, pb);
    write_cal(CFG_PRESS_C, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | 64'(pc));
  endtask

  // Sends one raw pair and queues its expected result once the beat is taken.
  // Called at a falling edge; returns at the falling edge after the beat with
  // tvalid still high, so back-to-back beats need no idle cycle.
  task automatic send_pair(logic [19:0] raw_t, logic [19:0] raw_p, bit allow_gap);
    int gap;
    gap = allow_gap ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {raw_p, raw_t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(compensate(raw_t, raw_p));
    @(negedge clk_i);
  endtask

  // Idles the input and waits for the pipeline to drain before touching the
  // calibration.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 5) @(negedge clk_i);
  endtask

  function automatic logic [19:0] rand_raw();
    case ($urandom_range(4))
      0: return 20'd0;
      1: return 20'hFFFFF;
      2: return 20'($urandom_range(600000, 400000));
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_word();
    return ($urandom_range(3) == 0) ? 16'(($urandom_range(1)) ? 16'h7FFF : 16'h8000)
                                    : 16'($urandom);
  endfunction

  // Typical calibration so most items reach the full pressure path.
  task automatic load_typical();
    load_cal({16'hFC18, 16'h6A4B, 16'h6E81},
             {16'h1B58, 16'hD0C3, 16'h0BD0, 16'h8F51},
             {16'h1770, 16'hFFF9, 16'h008C, 16'hFF7E},
             16'h1770);
  endtask

  task automatic test_reset_calibration();
    // All coefficients zero: the divisor is zero for every item.
    stall_bias = 0;
    send_pair(20'd0, 20'd0, 1'b0);
    send_pair(20'hFFFFF, 20'hFFFFF, 1'b0);
    send_pair(20'h80000, 20'h7FFFF, 1'b0);
    drain();
  endtask

  task automatic test_directed_extremes();
    logic [19:0] corners[4] = '{20'd0, 20'hFFFFF, 20'h80000, 20'h7FFFF};
    load_typical();
    foreach (corners[i])
      foreach (corners[j]) send_pair(corners[i], corners[j], 1'b0);
    drain();
    // Extreme coefficients in both directions.
    load_cal({3{16'h7FFF}} | 48'h8000, {4{16'h8000}}, {4{16'h7FFF}}, 16'h8000);
    send_pair(20'h65AC0, 20'h4B3A0, 1'b0);
    send_pair(20'hFFFFF, 20'd0, 1'b0);
    drain();
    load_cal({3{16'hFFFF}}, {4{16'hFFFF}}, {4{16'h8000}}, 16'h7FFF);
    send_pair(20'd0, 20'hFFFFF, 1'b0);
    send_pair(20'h51234, 20'h61234, 1'b0);
    drain();
  endtask

  task automatic test_random_calibration(int n_sets, int per_set);
    stall_bias = 1;
    for (int s = 0; s < n_sets; s++) begin
      if (s % 3 == 0) load_typical();
      else load_cal({rand_word(), rand_word(), rand_word()},
                    {rand_word(), rand_word(), rand_word(), rand_word()},
                    {rand_word(), rand_word(), rand_word(), rand_word()},
                    rand_word());
      for (int k = 0; k < per_set; k++) send_pair(rand_raw(), rand_raw(), 1'b1);
      drain();
    end
  endtask

  task automatic test_backpressure();
    // The receiver holds off while the sender keeps offering beats, so the
    // pipeline fills up and stalls its input.
    load_typical();
    stall_bias = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 150; k++) send_pair(20'($urandom), 20'($urandom), 1'b0);
    join
    drain();
  endtask

  // Receiver readiness, changed at the falling edge. Random stalls are mostly
  // short with a long one now and then.
  always @(negedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (stall_bias == 0) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall = rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(99) < 30) begin
      rx_stall = gap_len();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    comp_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.temp_centi = m_axis_tdata[23:0];
      got.press_fixed = m_axis_tdata[55:24];
      got.press_pa = m_axis_tdata[79:56];
      got.div_zero = m_axis_tuser;
      if (pending_results.size() == 0) begin
        unexpected_count++;
        if (mismatch_count + unexpected_count <= 10)
          $display("Unexpected result beat: %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: exp temp %h fixed %h pa %h dz %b, got %h %h %h %b",
                     want.temp_centi, want.press_fixed, want.press_pa, want.div_zero,
                     got.temp_centi, got.press_fixed, got.press_pa, got.div_zero);
        end
      end
    end
  end

  // Guard against a hung pipeline.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("barometric_sensor_compensation test failed");
      $finish;
    end
  end

  initial begin
    cal_temp = '0;
    cal_press_a = '0;
    cal_press_b = '0;
    cal_press_c = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_calibration();
    test_directed_extremes();
    test_random_calibration(12, 40);
    test_backpressure();
    drain();
    if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0)
      $display("barometric_sensor_compensation test passed");
    else
      $display("barometric_sensor_compensation test failed");
    $finish;
  end

endmodule
